// ----- hw/rtl/amdl_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and register codes of the arm motor drive limiter
package amdl_pkg;

    localparam int POS_W     = 16;
    localparam int SPEED_W   = 8;
    localparam int STEP_W    = 7;
    localparam int PWM_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // zone divisors
    localparam int DOWN_STOP_DIV_DEF = 8;
    localparam int DOWN_FINE_DIV_DEF = 4;
    localparam int DOWN_SLOW_DIV_DEF = 2;
    localparam int UP_FINE_DIV_DEF   = 4;
    localparam int UP_SLOW_DIV_DEF   = 2;

    // fixed point shift of the reciprocal used for the zone division
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // entries of the classify queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic signed [SPEED_W-1:0] DEADBAND_HI = 8'sd15;
    localparam logic signed [SPEED_W-1:0] DEADBAND_LO = -8'sd15;
    localparam logic signed [9:0]         SPEED_MAX   = 10'sd127;
    localparam logic signed [9:0]         SPEED_MIN   = -10'sd127;
    localparam logic signed [9:0]         PWM_MID     = 10'sd127;
    localparam logic signed [9:0]         PWM_TOP     = 10'sd254;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAMP_STEP     = 3'd0,
        REG_ALLOWED_ERROR = 3'd1,
        REG_DOWN_STOP_POS = 3'd2,
        REG_DOWN_FINE_POS = 3'd3,
        REG_DOWN_SLOW_POS = 3'd4,
        REG_UP_FINE_POS   = 3'd5,
        REG_UP_SLOW_POS   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0] ramp_step;
        logic [POS_W-1:0]  allowed_error;
        logic [POS_W-1:0]  down_stop_pos;
        logic [POS_W-1:0]  down_fine_pos;
        logic [POS_W-1:0]  down_slow_pos;
        logic [POS_W-1:0]  up_fine_pos;
        logic [POS_W-1:0]  up_slow_pos;
    } cfg_t;

    typedef struct packed {
        logic le_stop;
        logic le_fine;
        logic le_slow;
        logic ge_ufine;
        logic ge_uslow;
    } zone_t;

    typedef struct packed {
        logic                      manual;
        logic                      in_window;
        logic signed [SPEED_W-1:0] want;
        logic                      bot_n;
        logic                      top_n;
        zone_t                     zone;
    } q_item_t;

endpackage

// ----- hw/rtl/amdl_in_if.sv -----
`timescale 1ns / 1ps
// input item channel of the arm motor drive limiter
interface amdl_in_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [amdl_pkg::SPEED_W-1:0]         stick;
    logic signed [amdl_pkg::SPEED_W-1:0]         pid_speed;
    logic        [amdl_pkg::POS_W-1:0]           position;
    logic        [amdl_pkg::POS_W-1:0]           target_position;
    logic                                        bottom_limit_n;
    logic                                        top_limit_n;

    modport source (
        output valid, stick, pid_speed, position, target_position, bottom_limit_n,
               top_limit_n,
        input  ready
    );
    modport sink (
        input  valid, stick, pid_speed, position, target_position, bottom_limit_n,
               top_limit_n,
        output ready
    );
endinterface

// ----- hw/rtl/amdl_out_if.sv -----
`timescale 1ns / 1ps
// result item channel of the arm motor drive limiter
interface amdl_out_if;
    logic                          valid;
    logic                          ready;
    logic [amdl_pkg::PWM_W-1:0]    pwm;
    logic                          manual_mode;

    modport source (
        output valid, pwm, manual_mode,
        input  ready
    );
    modport sink (
        input  valid, pwm, manual_mode,
        output ready
    );
endinterface

// ----- hw/rtl/amdl_cfg_if.sv -----
`timescale 1ns / 1ps
// configuration write channel of the arm motor drive limiter
interface amdl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [amdl_pkg::CFG_IDX_W-1:0]    index;
    logic [amdl_pkg::CFG_DAT_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hw/rtl/amdl_cfg_regs.sv -----
`timescale 1ns / 1ps
// configuration register file
module amdl_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    amdl_cfg_if.sink        cfg,
    output amdl_pkg::cfg_t  regs
);

    amdl_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ramp_step     <= 7'd10;
            regs_reg.allowed_error <= 16'd20;
            regs_reg.down_stop_pos <= 16'd50;
            regs_reg.down_fine_pos <= 16'd150;
            regs_reg.down_slow_pos <= 16'd300;
            regs_reg.up_fine_pos   <= 16'd60000;
            regs_reg.up_slow_pos   <= 16'd55000;
        end
        else if (cfg.valid)
        begin
            case (amdl_pkg::cfg_index_t'(cfg.index))
                amdl_pkg::REG_RAMP_STEP:     regs_reg.ramp_step     <= cfg.data[6:0];
                amdl_pkg::REG_ALLOWED_ERROR: regs_reg.allowed_error <= cfg.data;
                amdl_pkg::REG_DOWN_STOP_POS: regs_reg.down_stop_pos <= cfg.data;
                amdl_pkg::REG_DOWN_FINE_POS: regs_reg.down_fine_pos <= cfg.data;
                amdl_pkg::REG_DOWN_SLOW_POS: regs_reg.down_slow_pos <= cfg.data;
                amdl_pkg::REG_UP_FINE_POS:   regs_reg.up_fine_pos   <= cfg.data;
                amdl_pkg::REG_UP_SLOW_POS:   regs_reg.up_slow_pos   <= cfg.data;
                default:                     ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/amdl_front.sv -----
`timescale 1ns / 1ps
// front end: accepts samples and classifies mode, target window and position zones
module amdl_front (
    amdl_in_if.sink              sample,
    input  amdl_pkg::cfg_t       regs,
    input  logic                 full,
    output logic                 push,
    output amdl_pkg::q_item_t    item
);

    logic [amdl_pkg::POS_W-1:0] win_lo;
    logic [amdl_pkg::POS_W:0]   win_hi;
    logic signed [8:0]          stick_ext;
    logic signed [8:0]          half_stick;

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    always_comb
    begin
        // lower window edge saturates at zero, upper edge keeps its carry
        win_lo = (sample.target_position >= regs.allowed_error)
               ? sample.target_position - regs.allowed_error : '0;
        win_hi = {1'b0, sample.target_position} + {1'b0, regs.allowed_error};

        // half the stick, truncated toward zero
        stick_ext  = {sample.stick[7], sample.stick};
        half_stick = (stick_ext + {8'd0, sample.stick[7]}) >>> 1;

        item.manual    = !(sample.stick <= amdl_pkg::DEADBAND_HI
                           && sample.stick >= amdl_pkg::DEADBAND_LO);
        item.in_window = (sample.position >= win_lo)
                         && ({1'b0, sample.position} <= win_hi);
        item.want      = item.manual ? half_stick[7:0] : sample.pid_speed;
        item.bot_n     = sample.bottom_limit_n;
        item.top_n     = sample.top_limit_n;

        item.zone.le_stop  = sample.position <= regs.down_stop_pos;
        item.zone.le_fine  = sample.position <= regs.down_fine_pos;
        item.zone.le_slow  = sample.position <= regs.down_slow_pos;
        item.zone.ge_ufine = sample.position >= regs.up_fine_pos;
        item.zone.ge_uslow = sample.position >= regs.up_slow_pos;
    end

endmodule

// ----- hw/rtl/amdl_queue.sv -----
`timescale 1ns / 1ps
// small fifo of classified items between front and back
module amdl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  amdl_pkg::q_item_t    push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output amdl_pkg::q_item_t    head_item
);

    localparam int DEPTH = amdl_pkg::QDEPTH;
    localparam int PW    = amdl_pkg::QPTR_W;
    localparam int CW    = amdl_pkg::QCNT_W;

    amdl_pkg::q_item_t mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");

endmodule

// ----- hw/rtl/amdl_back.sv -----
`timescale 1ns / 1ps
// back end: slew limit against last speed, then limit cutoff, zone division and pwm offset
module amdl_back #(
    parameter int DOWN_STOP_DIV = amdl_pkg::DOWN_STOP_DIV_DEF,
    parameter int DOWN_FINE_DIV = amdl_pkg::DOWN_FINE_DIV_DEF,
    parameter int DOWN_SLOW_DIV = amdl_pkg::DOWN_SLOW_DIV_DEF,
    parameter int UP_FINE_DIV   = amdl_pkg::UP_FINE_DIV_DEF,
    parameter int UP_SLOW_DIV   = amdl_pkg::UP_SLOW_DIV_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [amdl_pkg::STEP_W-1:0] ramp_step,
    input  logic                 head_valid,
    input  amdl_pkg::q_item_t    head_item,
    output logic                 pop,
    amdl_out_if.source           result
);

    localparam int SH = amdl_pkg::RECIP_SHIFT;
    localparam int RW = amdl_pkg::RECIP_W;

    // rounded-up reciprocals, exact for 8-bit magnitudes
    localparam logic [RW-1:0] R_STOP  = RW'(((1 << SH) + DOWN_STOP_DIV - 1) / DOWN_STOP_DIV);
    localparam logic [RW-1:0] R_FINE  = RW'(((1 << SH) + DOWN_FINE_DIV - 1) / DOWN_FINE_DIV);
    localparam logic [RW-1:0] R_SLOW  = RW'(((1 << SH) + DOWN_SLOW_DIV - 1) / DOWN_SLOW_DIV);
    localparam logic [RW-1:0] R_UFINE = RW'(((1 << SH) + UP_FINE_DIV - 1) / UP_FINE_DIV);
    localparam logic [RW-1:0] R_USLOW = RW'(((1 << SH) + UP_SLOW_DIV - 1) / UP_SLOW_DIV);
    localparam logic [RW-1:0] R_ONE   = RW'(1 << SH);

    // slew stage
    logic signed [7:0]  last_speed_reg;
    logic               s1_valid_reg;
    logic signed [7:0]  s1_speed_reg;
    logic               s1_manual_reg;
    logic               s1_bot_n_reg;
    logic               s1_top_n_reg;
    amdl_pkg::zone_t    s1_zone_reg;
    logic               s1_load;
    logic signed [7:0]  speed_next;
    logic signed [9:0]  want10;
    logic signed [9:0]  prev10;
    logic signed [9:0]  step10;
    logic signed [9:0]  slew10;

    // zone stage and output register
    logic               o_valid_reg;
    logic [7:0]         pwm_reg;
    logic               manual_reg;
    logic               o_free;
    logic [7:0]         pwm_next;
    logic               s_neg;
    logic               s_pos;
    logic               cut;
    logic signed [8:0]  s_ext;
    logic signed [8:0]  s_negated;
    logic [7:0]         mag;
    logic [RW-1:0]      recip;
    logic [RW+7:0]      prod;
    logic [7:0]         quot;
    logic signed [8:0]  zoned;
    logic signed [9:0]  drive;

    assign o_free  = !o_valid_reg || result.ready;
    assign s1_load = !s1_valid_reg || o_free;
    assign pop     = head_valid && s1_load;

    always_comb
    begin
        want10 = {{2{head_item.want[7]}}, head_item.want};
        prev10 = {{2{last_speed_reg[7]}}, last_speed_reg};
        step10 = {3'b000, ramp_step};
        if (want10 - prev10 > step10)
        begin
            slew10 = prev10 + step10;
        end
        else if (prev10 - want10 > step10)
        begin
            slew10 = prev10 - step10;
        end
        else
        begin
            slew10 = want10;
        end
        if ((want10 < 0 && slew10 > 0) || (want10 > 0 && slew10 < 0))
        begin
            slew10 = -slew10;
        end
        if (head_item.manual)
        begin
            if (slew10 < amdl_pkg::SPEED_MIN)
            begin
                slew10 = amdl_pkg::SPEED_MIN;
            end
            if (slew10 > amdl_pkg::SPEED_MAX)
            begin
                slew10 = amdl_pkg::SPEED_MAX;
            end
        end
        if (!head_item.manual && head_item.in_window)
        begin
            speed_next = '0;
        end
        else
        begin
            speed_next = slew10[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_speed_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= head_valid;
            end
            if (pop)
            begin
                last_speed_reg <= speed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_speed_reg  <= speed_next;
            s1_manual_reg <= head_item.manual;
            s1_bot_n_reg  <= head_item.bot_n;
            s1_top_n_reg  <= head_item.top_n;
            s1_zone_reg   <= head_item.zone;
        end
    end

    always_comb
    begin
        s_neg     = s1_speed_reg[7];
        s_pos     = !s1_speed_reg[7] && (s1_speed_reg != '0);
        cut       = (!s_pos && !s1_bot_n_reg) || (!s_neg && !s1_top_n_reg);
        s_ext     = {s1_speed_reg[7], s1_speed_reg};
        s_negated = -s_ext;
        mag       = s_neg ? s_negated[7:0] : s1_speed_reg[7:0];

        // down zones first, stop before fine before slow
        if (s_neg && s1_zone_reg.le_stop)
        begin
            recip = R_STOP;
        end
        else if (s_neg && s1_zone_reg.le_fine)
        begin
            recip = R_FINE;
        end
        else if (s_neg && s1_zone_reg.le_slow)
        begin
            recip = R_SLOW;
        end
        else if (s_pos && s1_zone_reg.ge_ufine)
        begin
            recip = R_UFINE;
        end
        else if (s_pos && s1_zone_reg.ge_uslow)
        begin
            recip = R_USLOW;
        end
        else
        begin
            recip = R_ONE;
        end

        prod  = {{RW{1'b0}}, mag} * {8'd0, recip};
        quot  = prod[SH+7:SH];
        zoned = s_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        if (cut)
        begin
            zoned = '0;
        end
        drive = {zoned[8], zoned} + amdl_pkg::PWM_MID;
        if (drive < 0)
        begin
            drive = '0;
        end
        else if (drive > amdl_pkg::PWM_TOP)
        begin
            drive = amdl_pkg::PWM_TOP;
        end
        pwm_next = drive[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_free)
        begin
            o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_free && s1_valid_reg)
        begin
            pwm_reg    <= pwm_next;
            manual_reg <= s1_manual_reg;
        end
    end

    assign result.valid       = o_valid_reg;
    assign result.pwm         = pwm_reg;
    assign result.manual_mode = manual_reg;

    a_last_speed: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> last_speed_reg == s1_speed_reg)
        else $error("last speed differs from the speed passed on");

    a_manual_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_manual_reg) |-> s1_speed_reg != -8'sd128)
        else $error("manual speed outside clamp range");

    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> pwm_reg != 8'd255)
        else $error("pwm above top of range");

endmodule

// ----- hw/rtl/arm_motor_drive_limiter_top.sv -----
`timescale 1ns / 1ps
// top level of the arm motor drive limiter
//
// One sample per control tick goes in on the sample channel and one result
// (pwm, manual_mode) comes out on the result channel, in order. The block
// takes one sample every clock cycle when the result side keeps up; each
// sample passes from the queue through the slew register to the output
// register. That rate is set by the slew stage, whose last-speed register is
// read and updated on each pop. The front end classifies each sample
// (deadband, target window, position zones) and writes it into a two-entry
// queue; the back end runs the slew limit, then the limit-switch cutoff,
// zone division by reciprocal multiply and the 127 offset with clamp, and
// holds the result in an output register, so up to three more samples are
// taken while a result waits before the sample side stalls. Registers are
// written through the cfg channel (always ready)
// by index in the order ramp_step, allowed_error, down_stop_pos,
// down_fine_pos, down_slow_pos, up_fine_pos, up_slow_pos; other indexes are
// ignored. Write them only while no sample is in flight.
module arm_motor_drive_limiter_top #(
    parameter int DOWN_STOP_DIV = amdl_pkg::DOWN_STOP_DIV_DEF,
    parameter int DOWN_FINE_DIV = amdl_pkg::DOWN_FINE_DIV_DEF,
    parameter int DOWN_SLOW_DIV = amdl_pkg::DOWN_SLOW_DIV_DEF,
    parameter int UP_FINE_DIV   = amdl_pkg::UP_FINE_DIV_DEF,
    parameter int UP_SLOW_DIV   = amdl_pkg::UP_SLOW_DIV_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    amdl_in_if.sink     sample,
    amdl_out_if.source  result,
    amdl_cfg_if.sink    cfg
);

    // configuration registers shared by front and back
    amdl_pkg::cfg_t     regs;

    // queue between front and back
    logic               push;
    logic               full;
    logic               pop;
    logic               head_valid;
    amdl_pkg::q_item_t  push_item;
    amdl_pkg::q_item_t  head_item;

    amdl_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // classify on the sample transfer, no state here
    amdl_front u_front (
        .sample (sample),
        .regs   (regs),
        .full   (full),
        .push   (push),
        .item   (push_item)
    );

    // decouples sample acceptance from result stalls
    amdl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // slew stage, then zone stage feeding the output register
    amdl_back #(
        .DOWN_STOP_DIV (DOWN_STOP_DIV),
        .DOWN_FINE_DIV (DOWN_FINE_DIV),
        .DOWN_SLOW_DIV (DOWN_SLOW_DIV),
        .UP_FINE_DIV   (UP_FINE_DIV),
        .UP_SLOW_DIV   (UP_SLOW_DIV)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ramp_step  (regs.ramp_step),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the arm motor drive limiter: predictor, scoreboard and stimulus
module tb;

    // index outside the register map, the block must ignore writes to it
    localparam logic [amdl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int POS_TOP  = 65535;
    localparam int LONG_HOLD = 60;

    typedef logic signed [amdl_pkg::SPEED_W-1:0] speed_t;
    typedef logic [amdl_pkg::POS_W-1:0]          pos_t;

    // one result transfer as the block should produce it
    typedef struct packed {
        logic [amdl_pkg::PWM_W-1:0] pwm;
        logic                       manual_mode;
    } drive_t;

    // predicts the drive value of every accepted sample and checks the results in order
    class drive_scoreboard;
        amdl_pkg::cfg_t regs;
        int     last_speed;
        drive_t drive_q[$];
        int     n_errors;
        int     n_samples;
        int     n_manual;
        int     n_window;
        int     n_cutoff;
        int     n_divided;
        int     n_clamped;

        function new();
            regs.ramp_step     = 7'd10;
            regs.allowed_error = 16'd20;
            regs.down_stop_pos = 16'd50;
            regs.down_fine_pos = 16'd150;
            regs.down_slow_pos = 16'd300;
            regs.up_fine_pos   = 16'd60000;
            regs.up_slow_pos   = 16'd55000;
            last_speed         = 0;
        endfunction

        function void write_reg(logic [amdl_pkg::CFG_IDX_W-1:0] idx,
                                logic [amdl_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                amdl_pkg::REG_RAMP_STEP:     regs.ramp_step     = data[amdl_pkg::STEP_W-1:0];
                amdl_pkg::REG_ALLOWED_ERROR: regs.allowed_error = data;
                amdl_pkg::REG_DOWN_STOP_POS: regs.down_stop_pos = data;
                amdl_pkg::REG_DOWN_FINE_POS: regs.down_fine_pos = data;
                amdl_pkg::REG_DOWN_SLOW_POS: regs.down_slow_pos = data;
                amdl_pkg::REG_UP_FINE_POS:   regs.up_fine_pos   = data;
                amdl_pkg::REG_UP_SLOW_POS:   regs.up_slow_pos   = data;
                default: ;
            endcase
        endfunction

        // slew limit against the previous speed, result flipped if it points the wrong way
        function int ramp_limit(int want, int prev);
            int step;
            int r;
            step = int'(regs.ramp_step);
            r = want;
            if (want - prev > step)
                r = prev + step;
            else if (prev - want > step)
                r = prev - step;
            if ((want < 0 && r > 0) || (want > 0 && r < 0))
                r = -r;
            return r;
        endfunction

        // limit-switch cutoff, then division near the travel ends
        function int zone_divide(int s, int pos, logic bot_n, logic top_n);
            if ((s <= 0 && !bot_n) || (s >= 0 && !top_n))
            begin
                n_cutoff++;
                return 0;
            end
            if (s < 0 && pos <= int'(regs.down_stop_pos))
            begin
                n_divided++;
                return s / amdl_pkg::DOWN_STOP_DIV_DEF;
            end
            if (s < 0 && pos <= int'(regs.down_fine_pos))
            begin
                n_divided++;
                return s / amdl_pkg::DOWN_FINE_DIV_DEF;
            end
            if (s < 0 && pos <= int'(regs.down_slow_pos))
            begin
                n_divided++;
                return s / amdl_pkg::DOWN_SLOW_DIV_DEF;
            end
            if (s > 0 && pos >= int'(regs.up_fine_pos))
            begin
                n_divided++;
                return s / amdl_pkg::UP_FINE_DIV_DEF;
            end
            if (s > 0 && pos >= int'(regs.up_slow_pos))
            begin
                n_divided++;
                return s / amdl_pkg::UP_SLOW_DIV_DEF;
            end
            return s;
        endfunction

        function void note_sample(speed_t stick, speed_t pid, pos_t pos, pos_t tgt,
                                  logic bot_n, logic top_n);
            int     st;
            int     lo;
            int     hi;
            int     speed;
            int     drv;
            logic   manual;
            drive_t d;
            st = int'(stick);
            manual = (st > int'(amdl_pkg::DEADBAND_HI)) || (st < int'(amdl_pkg::DEADBAND_LO));
            if (!manual)
            begin
                lo = (tgt >= regs.allowed_error) ? int'(tgt) - int'(regs.allowed_error) : 0;
                hi = int'(tgt) + int'(regs.allowed_error);
                if (int'(pos) >= lo && int'(pos) <= hi)
                begin
                    speed = 0;
                    n_window++;
                end
                else
                    speed = ramp_limit(int'(pid), last_speed);
            end
            else
            begin
                n_manual++;
                speed = ramp_limit(st / 2, last_speed);
                if (speed < int'(amdl_pkg::SPEED_MIN))
                    speed = int'(amdl_pkg::SPEED_MIN);
                if (speed > int'(amdl_pkg::SPEED_MAX))
                    speed = int'(amdl_pkg::SPEED_MAX);
            end
            last_speed = speed;
            drv = zone_divide(speed, int'(pos), bot_n, top_n) + int'(amdl_pkg::PWM_MID);
            if (drv < 0)
            begin
                drv = 0;
                n_clamped++;
            end
            else if (drv > int'(amdl_pkg::PWM_TOP))
            begin
                drv = int'(amdl_pkg::PWM_TOP);
                n_clamped++;
            end
            d.pwm = drv[amdl_pkg::PWM_W-1:0];
            d.manual_mode = manual;
            drive_q.push_back(d);
            n_samples++;
        endfunction

        function void check_result(logic [amdl_pkg::PWM_W-1:0] pwm, logic manual_mode);
            drive_t d;
            if (drive_q.size() == 0)
            begin
                $error("result with no sample pending: pwm %0d manual_mode %0d",
                       pwm, manual_mode);
                n_errors++;
                return;
            end
            d = drive_q.pop_front();
            if (pwm !== d.pwm)
            begin
                $error("pwm: expected %0d, actual %0d", d.pwm, pwm);
                n_errors++;
            end
            if (manual_mode !== d.manual_mode)
            begin
                $error("manual_mode: expected %0d, actual %0d", d.manual_mode, manual_mode);
                n_errors++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    amdl_in_if  in_ch();
    amdl_out_if out_ch();
    amdl_cfg_if cfg_ch();

    arm_motor_drive_limiter_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    drive_scoreboard sb = new();

    // settings currently loaded, used to aim positions at the zone edges
    amdl_pkg::cfg_t cur_cfg;
    int   n_settings;
    int   n_in_stalls;

    // flow control knobs set by the stimulus, read by the sender and the receiver
    bit tx_steady;
    bit rx_steady;
    int rx_hold_req;

    // state of the current run of similar samples
    int run_left;
    int run_stick;
    int run_pid;
    int run_tgt;
    int run_pos;

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard limit on the run time, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls per result, steady stretches and one long hold-off
    initial
    begin
        int stall;
        int holds_served;
        holds_served = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_steady ? 0 : int'($urandom_range(0, 5));
            if (rx_hold_req > holds_served)
            begin
                // long hold-off so the block fills up and stalls its sample side
                stall = LONG_HOLD;
                holds_served++;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            sb.check_result(out_ch.pwm, out_ch.manual_mode);
        end
    end

    // offer one sample after a random gap and hold it until the transfer
    task automatic send_sample(int stk, int pid, int pos, int tgt, logic bot_n, logic top_n);
        int gap;
        gap = tx_steady ? 0 : int'($urandom_range(0, 5));
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.stick           <= speed_t'(stk);
        in_ch.pid_speed       <= speed_t'(pid);
        in_ch.position        <= pos_t'(pos);
        in_ch.target_position <= pos_t'(tgt);
        in_ch.bottom_limit_n  <= bot_n;
        in_ch.top_limit_n     <= top_n;
        do
        begin
            @(posedge clk);
            if (in_ch.ready !== 1'b1)
                n_in_stalls++;
        end
        while (in_ch.ready !== 1'b1);
        sb.note_sample(speed_t'(stk), speed_t'(pid), pos_t'(pos), pos_t'(tgt), bot_n, top_n);
    endtask

    // stop offering samples until every predicted result has been checked
    task automatic drain();
        if (in_ch.valid)
            in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [amdl_pkg::CFG_IDX_W-1:0] idx,
                             logic [amdl_pkg::CFG_DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // load a full register set, only called while nothing is in flight
    task automatic program_regs(amdl_pkg::cfg_t c);
        cfg_write(REG_UNUSED, 16'($urandom));
        // upper data bits above the 7-bit step are junk and must be dropped
        cfg_write(amdl_pkg::REG_RAMP_STEP, {9'($urandom), c.ramp_step});
        cfg_write(amdl_pkg::REG_ALLOWED_ERROR, c.allowed_error);
        cfg_write(amdl_pkg::REG_DOWN_STOP_POS, c.down_stop_pos);
        cfg_write(amdl_pkg::REG_DOWN_FINE_POS, c.down_fine_pos);
        cfg_write(amdl_pkg::REG_DOWN_SLOW_POS, c.down_slow_pos);
        cfg_write(amdl_pkg::REG_UP_FINE_POS, c.up_fine_pos);
        cfg_write(amdl_pkg::REG_UP_SLOW_POS, c.up_slow_pos);
        cfg_ch.valid <= 1'b0;
        cur_cfg = c;
        n_settings++;
    endtask

    // register set with a bias toward the extremes and mostly ordered zone edges
    function automatic amdl_pkg::cfg_t random_cfg();
        amdl_pkg::cfg_t c;
        int   s;
        case ($urandom_range(0, 7))
            0:       c.ramp_step = 7'd127;
            1:       c.ramp_step = 7'd1;
            2:       c.ramp_step = 7'd0;
            default: c.ramp_step = 7'($urandom_range(1, 127));
        endcase
        case ($urandom_range(0, 5))
            0:       c.allowed_error = 16'd0;
            1:       c.allowed_error = 16'(POS_TOP);
            2, 3:    c.allowed_error = 16'($urandom_range(0, 200));
            default: c.allowed_error = 16'($urandom_range(0, POS_TOP));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            // unordered edges, zone priority decides
            c.down_stop_pos = 16'($urandom_range(0, POS_TOP));
            c.down_fine_pos = 16'($urandom_range(0, POS_TOP));
            c.down_slow_pos = 16'($urandom_range(0, POS_TOP));
            c.up_fine_pos   = 16'($urandom_range(0, POS_TOP));
            c.up_slow_pos   = 16'($urandom_range(0, POS_TOP));
        end
        else
        begin
            s = int'($urandom_range(0, 400));
            c.down_stop_pos = 16'(s);
            s = s + int'($urandom_range(0, 400));
            c.down_fine_pos = 16'(s);
            s = s + int'($urandom_range(0, 800));
            c.down_slow_pos = 16'(s);
            s = int'($urandom_range(40000, 60000));
            c.up_slow_pos = 16'(s);
            s = s + int'($urandom_range(0, 5535));
            c.up_fine_pos = 16'(s);
        end
        return c;
    endfunction

    // random position within spread of center, held inside the encoder range
    function automatic int pick_near(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > POS_TOP)
            v = POS_TOP;
        return v;
    endfunction

    // runs of samples with a steady stick and pid request so the slew limit
    // ramps toward them, while the position creeps around a chosen spot
    task automatic send_random();
        int   mag;
        logic bot_n;
        logic top_n;
        if (run_left == 0)
        begin
            run_left = int'($urandom_range(1, 8));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_stick = int'($urandom_range(0, 30)) - 15;
                4, 5, 6, 7:
                begin
                    mag = int'($urandom_range(16, 127));
                    run_stick = $urandom_range(0, 1) ? mag : -mag;
                end
                default: run_stick = int'($urandom_range(0, 254)) - 127;
            endcase
            case ($urandom_range(0, 7))
                0:       run_pid = -128;
                1:       run_pid = 127;
                default: run_pid = int'($urandom_range(0, 255)) - 128;
            endcase
            case ($urandom_range(0, 7))
                0:       run_tgt = 0;
                1:       run_tgt = POS_TOP;
                default: run_tgt = int'($urandom_range(0, POS_TOP));
            endcase
            case ($urandom_range(0, 8))
                0, 1:    run_pos = pick_near(run_tgt, int'(cur_cfg.allowed_error) + 3);
                2:       run_pos = pick_near(int'(cur_cfg.down_stop_pos), 3);
                3:       run_pos = pick_near(int'(cur_cfg.down_fine_pos), 3);
                4:       run_pos = pick_near(int'(cur_cfg.down_slow_pos), 3);
                5:       run_pos = pick_near(int'(cur_cfg.up_fine_pos), 3);
                6:       run_pos = pick_near(int'(cur_cfg.up_slow_pos), 3);
                7:       run_pos = $urandom_range(0, 1) ? 0 : POS_TOP;
                default: run_pos = int'($urandom_range(0, POS_TOP));
            endcase
        end
        else
            run_pos = pick_near(run_pos, 3);
        run_left--;
        bot_n = ($urandom_range(0, 6) != 0);
        top_n = ($urandom_range(0, 6) != 0);
        send_sample(run_stick, run_pid, run_pos, run_tgt, bot_n, top_n);
    endtask

    // a block of random samples; optional long result hold-off and mid-phase pause
    task automatic random_phase(int n_items, int hold_at, int pause_at);
        for (int i = 0; i < n_items; i++)
        begin
            // every 30 samples pick whether either side runs without gaps
            if (i % 30 == 0)
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if (i == hold_at)
            begin
                rx_hold_req++;
                tx_steady = 1'b1;
            end
            if (i == pause_at)
                drain();
            send_random();
        end
        drain();
    endtask

    initial
    begin
        amdl_pkg::cfg_t c;

        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.stick           = '0;
        in_ch.pid_speed       = '0;
        in_ch.position        = '0;
        in_ch.target_position = '0;
        in_ch.bottom_limit_n  = 1'b1;
        in_ch.top_limit_n     = 1'b1;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        tx_steady             = 1'b0;
        rx_steady             = 1'b0;
        rx_hold_req           = 0;
        run_left              = 0;
        n_settings            = 1;
        n_in_stalls           = 0;
        cur_cfg               = sb.regs;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed samples with the reset settings
        send_sample(0, 0, 1000, 1000, 1'b1, 1'b1);        // stick centered, on target
        send_sample(0, 127, 5000, 1000, 1'b1, 1'b1);      // full pid request ramps by the step
        send_sample(0, 127, 5000, 1000, 1'b1, 1'b1);
        send_sample(127, 0, 5000, 1000, 1'b1, 1'b1);      // manual full up, half stick
        send_sample(-127, 0, 5000, 1000, 1'b1, 1'b1);     // reversal, slew result gets negated
        send_sample(15, -128, 0, 100, 1'b1, 1'b1);        // deadband edge, pid minimum, stop zone
        send_sample(-15, 0, 0, 10, 1'b1, 1'b1);           // window lower edge saturates at zero
        send_sample(16, 0, 2000, 0, 1'b1, 1'b1);          // just outside the deadband
        send_sample(-16, 0, 2000, 0, 1'b1, 1'b1);
        send_sample(0, 50, 1000, 1000, 1'b0, 1'b0);       // zero speed, both switches pressed
        send_sample(-100, 0, 1000, 0, 1'b0, 1'b1);        // moving down onto the bottom switch
        send_sample(100, 0, 1000, 0, 1'b1, 1'b0);         // moving up onto the top switch
        send_sample(100, 0, 1000, 0, 1'b0, 1'b1);         // upward passes the bottom switch
        send_sample(-127, 0, 300, 0, 1'b1, 1'b1);         // down zones, slow / fine / stop edges
        send_sample(-127, 0, 151, 0, 1'b1, 1'b1);
        send_sample(-127, 0, 150, 0, 1'b1, 1'b1);
        send_sample(-127, 0, 50, 0, 1'b1, 1'b1);
        send_sample(127, 0, 55000, 0, 1'b1, 1'b1);        // up zones, slow / fine edges
        send_sample(127, 0, 59999, 0, 1'b1, 1'b1);
        send_sample(127, 0, 60000, 0, 1'b1, 1'b1);
        send_sample(0, 127, 65535, 65530, 1'b1, 1'b1);    // window upper edge above 16 bits
        send_sample(0, 127, 0, 65535, 1'b1, 1'b1);
        drain();

        // widest step, zero-width window, down zones only at position zero, up fine zone only at the very top
        c = '{ramp_step: 7'd127, allowed_error: 16'd0, down_stop_pos: 16'd0,
              down_fine_pos: 16'd0, down_slow_pos: 16'd0, up_fine_pos: 16'(POS_TOP),
              up_slow_pos: 16'(POS_TOP)};
        program_regs(c);
        send_sample(0, -128, 5, 0, 1'b1, 1'b1);           // speed -128 kept, pwm clamps at zero
        send_sample(0, -128, 5, 0, 1'b1, 1'b1);
        send_sample(0, 127, 65535, 0, 1'b1, 1'b1);        // full swing past zero flips the sign
        send_sample(0, 127, 65535, 0, 1'b1, 1'b1);
        send_sample(0, 0, 0, 0, 1'b1, 1'b1);              // zero-width window, exact hit
        random_phase(100, -1, -1);

        // zero step holds the magnitude of the last speed, window and zones cover everything
        c = '{ramp_step: 7'd0, allowed_error: 16'(POS_TOP), down_stop_pos: 16'(POS_TOP),
              down_fine_pos: 16'(POS_TOP), down_slow_pos: 16'(POS_TOP), up_fine_pos: 16'd0,
              up_slow_pos: 16'd0};
        program_regs(c);
        random_phase(70, -1, -1);

        // slowest nonzero ramp with a narrow window
        c = '{ramp_step: 7'd1, allowed_error: 16'd5, down_stop_pos: 16'd100,
              down_fine_pos: 16'd200, down_slow_pos: 16'd400, up_fine_pos: 16'd65000,
              up_slow_pos: 16'd50000};
        program_regs(c);
        random_phase(60, -1, -1);

        // random settings; one phase holds the result side off, one pauses the sender
        for (int k = 0; k < 7; k++)
        begin
            program_regs(random_cfg());
            random_phase(100, (k == 1) ? 35 : -1, (k == 2) ? 50 : -1);
        end

        // catch any stray result after the last expected one
        repeat (10) @(posedge clk);

        $display("covered %0d samples over %0d register settings: %0d manual, %0d in window",
                 sb.n_samples, n_settings, sb.n_manual, sb.n_window);
        $display("%0d switch cutoffs, %0d zone divisions, %0d pwm clamps, %0d stalled cycles",
                 sb.n_cutoff, sb.n_divided, sb.n_clamped, n_in_stalls);
        if (sb.n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/amdl_pkg.sv
hw/rtl/amdl_in_if.sv
hw/rtl/amdl_out_if.sv
hw/rtl/amdl_cfg_if.sv
hw/rtl/amdl_cfg_regs.sv
hw/rtl/amdl_front.sv
hw/rtl/amdl_queue.sv
hw/rtl/amdl_back.sv
hw/rtl/arm_motor_drive_limiter_top.sv
sim/tb.sv
